// ===== rtl/rhsv_pkg.sv =====
// Shared types, constants and the divider step for the RGB to HSV converter.
package rhsv_pkg;

  // Field widths.
  localparam int ChanW = 8;
  localparam int HueW  = 9;
  localparam int PctW  = 7;

  // Divider geometry: numerator/remainder width, divisor width, quotient bits.
  localparam int NumW = 18;
  localparam int DenW = 9;
  localparam int QuoW = 9;

  // Number of cells in the divider chain, one quotient bit each.
  localparam int NumCells = QuoW;

  // Sector offsets (in units of 60 degrees).
  localparam logic [2:0] SectRed     = 3'd0;
  localparam logic [2:0] SectGreen   = 3'd2;
  localparam logic [2:0] SectBlue    = 3'd4;
  localparam logic [2:0] SectRedWrap = 3'd6;

  // Brightness: floor((200*v + 255) / 510) by reciprocal, shift of 24.
  localparam int          BriShift = 24;
  localparam logic [15:0] BriRecip = 16'd32897;

  // Largest legal output values.
  localparam logic [HueW-1:0] HueMax = 9'd360;
  localparam logic [PctW-1:0] PctMax = 7'd100;

  // One division in flight: partial remainder, shifted divisor, quotient so far.
  typedef struct packed {
    logic [NumW-1:0] rem;
    logic [NumW-1:0] dsh;
    logic [QuoW-1:0] quo;
  } div_lane_t;

  // Everything that travels down the divider chain for one pixel.
  typedef struct packed {
    div_lane_t       hue;
    div_lane_t       sat;
    logic [PctW-1:0] bri;
  } div_data_t;

  // One restoring-division step: try to subtract the shifted divisor.
  function automatic div_lane_t div_step(div_lane_t l);
    div_lane_t r;
    r.dsh = l.dsh >> 1;
    if (l.rem >= l.dsh) begin
      r.rem = l.rem - l.dsh;
      r.quo = {l.quo[QuoW-2:0], 1'b1};
    end else begin
      r.rem = l.rem;
      r.quo = {l.quo[QuoW-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// ===== rtl/rhsv_front.sv =====
// Front end: max/min and sector pick, then dividend/divisor setup and brightness.
module rhsv_front
  import rhsv_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [ChanW-1:0] red,
  input  logic [ChanW-1:0] green,
  input  logic [ChanW-1:0] blue,
  output logic             out_valid,
  output div_data_t        out_data
);

  // Stage 0 combinational: extremes, chroma and sector.
  logic [ChanW-1:0] v_c, mn_c, n_c;
  logic [2:0]       off_c;
  logic signed [ChanW:0] diff_c;

  always_comb begin
    v_c = red;
    if (green > v_c) v_c = green;
    if (blue > v_c) v_c = blue;
    mn_c = red;
    if (green < mn_c) mn_c = green;
    if (blue < mn_c) mn_c = blue;
    n_c = v_c - mn_c;
    // Red wins ties over green, green over blue.
    if (v_c == red) begin
      off_c  = (green >= blue) ? SectRed : SectRedWrap;
      diff_c = $signed({1'b0, green}) - $signed({1'b0, blue});
    end else if (v_c == green) begin
      off_c  = SectGreen;
      diff_c = $signed({1'b0, blue}) - $signed({1'b0, red});
    end else begin
      off_c  = SectBlue;
      diff_c = $signed({1'b0, red}) - $signed({1'b0, green});
    end
  end

  // Stage 0 registers.
  logic                  s0_valid;
  logic [ChanW-1:0]      s0_v, s0_n;
  logic [2:0]            s0_off;
  logic signed [ChanW:0] s0_diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_v    <= v_c;
      s0_n    <= n_c;
      s0_off  <= off_c;
      s0_diff <= diff_c;
    end
  end

  // Stage 1 combinational: hue N = 120*(off*n + diff) + n, D = 2n;
  // saturation N = 200*n + v, D = 2v; brightness by reciprocal.
  logic signed [11:0] t_s;
  logic [10:0]        t_c;
  logic [NumW-1:0]    hue_num, sat_num;
  logic [DenW-1:0]    hue_den, sat_den;
  logic [15:0]        bri_x;
  logic [31:0]        bri_p;
  div_data_t          d_c;

  always_comb begin
    t_s     = $signed({1'b0, 11'(s0_off) * 11'(s0_n)}) + 12'(s0_diff);
    t_c     = t_s[10:0];
    hue_num = NumW'(18'd120 * NumW'(t_c)) + NumW'(s0_n);
    hue_den = {s0_n, 1'b0};
    sat_num = NumW'(18'd200 * NumW'(s0_n)) + NumW'(s0_v);
    sat_den = {s0_v, 1'b0};
    // A zero divisor only occurs with a zero dividend; use 2 to give quotient 0.
    if (s0_n == '0) begin
      hue_num = '0;
      hue_den = DenW'(2);
    end
    if (s0_v == '0) begin
      sat_num = '0;
      sat_den = DenW'(2);
    end
    bri_x = 16'(16'd200 * 16'(s0_v)) + 16'd255;
    bri_p = 32'(bri_x) * 32'(BriRecip);

    d_c.hue.rem = hue_num;
    d_c.hue.dsh = NumW'({hue_den, {(QuoW-1){1'b0}}});
    d_c.hue.quo = '0;
    d_c.sat.rem = sat_num;
    d_c.sat.dsh = NumW'({sat_den, {(QuoW-1){1'b0}}});
    d_c.sat.quo = '0;
    d_c.bri     = bri_p[BriShift+PctW-1:BriShift];
  end

  // Stage 1 registers feed the first divider cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= d_c;
    end
  end

endmodule

// ===== rtl/rhsv_div_cell.sv =====
// One cell of the divider chain: resolves one quotient bit for hue and saturation.
module rhsv_div_cell
  import rhsv_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      in_valid,
  input  div_data_t in_data,
  output logic      out_valid,
  output div_data_t out_data
);

  // Valid bit of this cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // Subtract step on both lanes; brightness rides along.
  always_ff @(posedge clk) begin
    if (en) begin
      out_data.hue <= div_step(in_data.hue);
      out_data.sat <= div_step(in_data.sat);
      out_data.bri <= in_data.bri;
    end
  end

endmodule

// ===== rtl/rgb_to_hsv_converter_top.sv =====
// Input transaction to result passes 2 front stages, then 9 divider cells.
// Throughput: one pixel per cycle; the 9-cell restoring divider chain is fully pipelined.
// The whole pipeline advances together and holds when a result waits on m_tready.
// Reset (rst, synchronous) clears every valid bit; payload registers are not reset.
// Top level of the RGB to HSV converter.
module rgb_to_hsv_converter_top
  import rhsv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // red[7:0], green[15:8], blue[23:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata   // hue[8:0], saturation[15:9], brightness[22:16], zero[23]
);

  // Global advance: move when the output register is empty or being taken.
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Chain links: index 0 is the front end output.
  logic      link_valid [NumCells+1];
  div_data_t link_data  [NumCells+1];

  rhsv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .red       (s_tdata[7:0]),
    .green     (s_tdata[15:8]),
    .blue      (s_tdata[23:16]),
    .out_valid (link_valid[0]),
    .out_data  (link_data[0])
  );

  // Row of divider cells, each handing its partial result to the next.
  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    rhsv_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (link_valid[i]),
      .in_data   (link_data[i]),
      .out_valid (link_valid[i+1]),
      .out_data  (link_data[i+1])
    );
  end

  // The last cell is the output register.
  div_data_t res;
  assign res      = link_data[NumCells];
  assign m_tvalid = link_valid[NumCells];
  assign m_tdata  = {1'b0, res.bri, res.sat.quo[PctW-1:0], res.hue.quo};

  // Results stay in range, and saturation never needs its top quotient bits.
  a_hue_range : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> res.hue.quo <= HueMax)
    else $error("hue above 360");

  a_sat_range : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (res.sat.quo[QuoW-1:PctW] == '0) && (res.sat.quo[PctW-1:0] <= PctMax))
    else $error("saturation out of range");

  a_bri_range : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> res.bri <= PctMax)
    else $error("brightness above 100");

  a_rem_below_div : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (res.hue.rem <= {res.hue.dsh[NumW-2:0], 1'b0})
              && (res.sat.rem <= {res.sat.dsh[NumW-2:0], 1'b0}))
    else $error("divider remainder not reduced");

  a_reset_empty : assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule
